>>> hw/rtl/wdfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wdfc_pkg
// Shared constants, types and bit-level helpers for the descrambler and
// FCS check block.
// ----------------------------------------------------------------------------
package wdfc_pkg;

  localparam int unsigned LEN_W = 12;   // psdu_bytes width
  localparam int unsigned POS_W = 16;   // holds len*8 + 16 for any 12-bit length
  localparam int unsigned SCR_W = 7;    // scrambler register width
  localparam int unsigned BYTE_IDX_W = POS_W - 3;

  localparam logic [POS_W-1:0] SEED_BITS    = POS_W'(7);
  localparam logic [POS_W-1:0] SERVICE_BITS = POS_W'(16);
  localparam logic [2:0]       SEED_MSB     = 3'd6;
  localparam logic [POS_W-1:0] MAX_PSDU_LEN = POS_W'(4095);

  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
  // Final-xored residue 0x2144DF1C, compared before the final xor
  localparam logic [31:0] CRC_RESIDUE = 32'h2144_DF1C;
  localparam logic [31:0] CRC_MATCH   = ~CRC_RESIDUE;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       byte_is_fcs;
    logic       last_byte;
    logic       fcs_ok;
  } result_t;

  // One step of the reflected CRC-32
  function automatic logic [31:0] crc_bit(input logic [31:0] c, input logic b);
    logic [31:0] t;
    t = {c[31:1], c[0] ^ b};
    crc_bit = t[0] ? ((t >> 1) ^ CRC_POLY) : (t >> 1);
  endfunction

endpackage : wdfc_pkg
`default_nettype wire

>>> hw/rtl/wdfc_descrambler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wdfc_descrambler
// Frame state, descrambler, byte packer and CRC-32. Consumes one bit per
// step and presents the byte result combinationally.
// ----------------------------------------------------------------------------
module wdfc_descrambler (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     step,
  input  wire logic                     data_bit,
  input  wire logic                     frame_start,
  input  wire logic [wdfc_pkg::LEN_W-1:0] psdu_bytes,
  output wdfc_pkg::result_t             result
);
  import wdfc_pkg::*;

  logic [SCR_W-1:0] scrambler_state, scrambler_state_next;
  logic [POS_W-1:0] bit_position, bit_position_next;
  logic [7:0]       byte_assembly, byte_assembly_next;
  logic [31:0]      crc_register, crc_register_next;
  logic [LEN_W-1:0] frame_length, frame_length_next;
  logic             frame_active, frame_active_next;

  // Working values after a possible frame restart
  logic [SCR_W-1:0]      scr_w;
  logic [POS_W-1:0]      pos_w;
  logic [7:0]            asm_w;
  logic [31:0]           crc_w;
  logic [LEN_W-1:0]      len_w;
  logic                  act_w;
  logic [POS_W-1:0]      total;
  logic                  fb;
  logic                  dbit;
  logic [2:0]            seed_idx;
  logic [7:0]            byte_new;
  logic [31:0]           crc_new;
  logic [POS_W-1:0]      svc_off;
  logic [BYTE_IDX_W-1:0] byte_idx;

  always_comb begin
    scr_w = scrambler_state;
    pos_w = bit_position;
    asm_w = byte_assembly;
    crc_w = crc_register;
    len_w = frame_length;
    act_w = frame_active;
    // Restart discards any frame in progress
    if (frame_start) begin
      scr_w = '0;
      pos_w = '0;
      asm_w = '0;
      crc_w = CRC_INIT;
      len_w = psdu_bytes;
      act_w = (POS_W'(psdu_bytes) <= MAX_PSDU_LEN);
    end

    total    = {1'b0, len_w, 3'b000} + SERVICE_BITS;
    fb       = scr_w[6] ^ scr_w[3];
    dbit     = fb ^ data_bit;
    seed_idx = SEED_MSB - pos_w[2:0];
    byte_new = asm_w | (8'(dbit) << pos_w[2:0]);
    crc_new  = crc_bit(crc_w, dbit);
    svc_off  = pos_w - SERVICE_BITS;
    byte_idx = svc_off[POS_W-1:3];

    scrambler_state_next = scr_w;
    bit_position_next    = pos_w;
    byte_assembly_next   = asm_w;
    crc_register_next    = crc_w;
    frame_length_next    = len_w;
    frame_active_next    = act_w;

    result             = '0;
    result.data_byte   = byte_new;
    result.byte_is_fcs = ({1'b0, byte_idx} + (BYTE_IDX_W+1)'(4)) >=
                         (BYTE_IDX_W+1)'(len_w);
    result.last_byte   = (byte_idx + BYTE_IDX_W'(1)) == BYTE_IDX_W'(len_w);
    result.fcs_ok      = result.last_byte && (crc_new == CRC_MATCH);

    if (act_w) begin
      if (pos_w < SEED_BITS) begin
        // Load seed, MSB first
        scrambler_state_next = scr_w | (SCR_W'(data_bit) << seed_idx);
      end else begin
        // Advance scrambler; pack and check PSDU bits past the service field
        scrambler_state_next = {scr_w[5:0], fb};
        if (pos_w >= SERVICE_BITS) begin
          byte_assembly_next = byte_new;
          crc_register_next  = crc_new;
          if (pos_w[2:0] == 3'd7) begin
            result.valid       = 1'b1;
            byte_assembly_next = '0;
          end
        end
      end
      bit_position_next = pos_w + POS_W'(1);
      if (bit_position_next >= total) begin
        frame_active_next = 1'b0;
      end
    end
    if (!act_w) begin
      result.fcs_ok = 1'b0;
    end
  end

  // Update frame state on each consumed bit
  always_ff @(posedge clk) begin
    if (rst) begin
      scrambler_state <= '0;
      bit_position    <= '0;
      byte_assembly   <= '0;
      crc_register    <= CRC_INIT;
      frame_length    <= '0;
      frame_active    <= 1'b0;
    end else if (step) begin
      scrambler_state <= scrambler_state_next;
      bit_position    <= bit_position_next;
      byte_assembly   <= byte_assembly_next;
      crc_register    <= crc_register_next;
      frame_length    <= frame_length_next;
      frame_active    <= frame_active_next;
    end
  end

endmodule : wdfc_descrambler
`default_nettype wire

>>> hw/rtl/wlan_descrambler_fcs_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wlan_descrambler_fcs_check
// Descrambles decoded frame bits, packs PSDU bytes and checks the CRC-32 FCS.
// ----------------------------------------------------------------------------
// Path: the bit completing a byte is taken into the input register, and the byte
//   then appears on the output from the output register.
// Throughput: one bit per cycle while byte_stall does not hold the output; the
//   scrambler and CRC advance one bit per step in the single logic stage between the two registers.
// Reset: synchronous; clears pipeline valids and returns the frame state to
//   idle with the CRC at all ones.
module wlan_descrambler_fcs_check (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // Bit channel
  input  wire logic                     bit_valid,
  output      logic                     bit_stall,
  input  wire logic                     data_bit,
  input  wire logic                     frame_start,
  input  wire logic [wdfc_pkg::LEN_W-1:0] psdu_bytes,
  // Byte channel
  output      logic                     byte_valid,
  input  wire logic                     byte_stall,
  output      logic [7:0]               data_byte,
  output      logic                     byte_is_fcs,
  output      logic                     last_byte,
  output      logic                     fcs_ok
);
  import wdfc_pkg::*;

  logic             in_valid;
  logic             in_bit;
  logic             in_start;
  logic [LEN_W-1:0] in_len;
  logic             out_free;
  logic             step;
  result_t          result;

  assign out_free  = !byte_valid || !byte_stall;
  assign step      = in_valid && out_free;
  assign bit_stall = in_valid && !out_free;

  // Hold the input transaction until the output side can take its result
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!bit_stall) begin
      in_valid <= bit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!bit_stall && bit_valid) begin
      in_bit   <= data_bit;
      in_start <= frame_start;
      in_len   <= psdu_bytes;
    end
  end

  wdfc_descrambler u_descrambler (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .data_bit    (in_bit),
    .frame_start (in_start),
    .psdu_bytes  (in_len),
    .result      (result)
  );

  // Output register; drop bits that complete no byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (out_free) begin
      byte_valid <= step && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result.valid) begin
      data_byte   <= result.data_byte;
      byte_is_fcs <= result.byte_is_fcs;
      last_byte   <= result.last_byte;
      fcs_ok      <= result.fcs_ok;
    end
  end

endmodule : wlan_descrambler_fcs_check
`default_nettype wire
